/* hw/rtl/ptw_pkg.sv */
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, types and the table-entry address function for the
// four-level page table walk presence block.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // store depth in 64-bit words, a power of two between 512 and 1048576
  localparam int unsigned TABLE_WORDS = 4096;
  localparam int unsigned ADDR_W      = $clog2(TABLE_WORDS);

  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned ROOT_W  = 52;
  localparam int unsigned VA_W    = 48;
  localparam int unsigned WIDX_W  = 12;
  localparam int unsigned IDX_W   = 9;

  localparam int unsigned L4_SHIFT = 39;
  localparam int unsigned L3_SHIFT = 30;
  localparam int unsigned L2_SHIFT = 21;
  localparam int unsigned L1_SHIFT = 12;

  localparam int unsigned BASE_LSB     = 12;
  localparam int unsigned BIT_PRESENT  = 0;
  localparam int unsigned BIT_PAGESIZE = 7;

  // request type codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [ROOT_W-1:0]  root_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } mem_req_t;

  // word address of entry idx in the table whose byte base is base[51:12]
  function automatic addr_t entry_addr(root_t base, idx_t idx);
    logic [ROOT_W-BASE_LSB+IDX_W-1:0] word;
    word = {base[ROOT_W-1:BASE_LSB], idx};
    return word[ADDR_W-1:0];
  endfunction

endpackage

/* hw/rtl/page_table_walk_presence.sv */
// ----------------------------------------------------------------------------
// page_table_walk_presence
// Four-level x86-64 page table walk over a local store of table words.
// ----------------------------------------------------------------------------
// After reset the block clears all TABLE_WORDS (4096) store words with busy
// high; root register writes are taken during that time. An entry
// write is taken and gives no result. A query keeps the block busy for
// one walk step per table level visited (one to four), since each level
// needs the previous entry from the single-read-port store; the mapped
// answer appears on mapped_o with result_strobe_o for exactly one cycle,
// registered after the last walk step, and busy is already low in that cycle.
// The receiver cannot stall: the result must be captured when the strobe is
// high.
module page_table_walk_presence (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type_i,
  input  logic [ptw_pkg::WIDX_W-1:0]       word_index_i,
  input  logic [ptw_pkg::ENTRY_W-1:0]      entry_value_i,
  input  logic [ptw_pkg::VA_W-1:0]         virt_addr_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ptw_pkg::ROOT_W-1:0]       cfg_data_i,
  output logic                             result_strobe_o,
  output logic                             mapped_o
);
  import ptw_pkg::*;

  root_t    root_q;
  mem_req_t mem_req;
  entry_t   rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      root_q <= cfg_data_i;
    end
  end

  ptw_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .word_index_i    (word_index_i),
    .entry_value_i   (entry_value_i),
    .virt_addr_i     (virt_addr_i),
    .root_i          (root_q),
    .mem_req_o       (mem_req),
    .rdata_i         (rdata),
    .result_strobe_o (result_strobe_o),
    .mapped_o        (mapped_o)
  );

  ptw_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

endmodule

/* hw/rtl/ptw_store.sv */
// ----------------------------------------------------------------------------
// ptw_store
// Page-table word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ptw_store (
  input  logic              clk_i,
  input  ptw_pkg::mem_req_t req_i,
  output ptw_pkg::entry_t   rdata_o
);
  import ptw_pkg::*;

  entry_t mem_q [TABLE_WORDS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/ptw_ctrl.sv */
// ----------------------------------------------------------------------------
// ptw_ctrl
// Walk sequencer: clears the store after reset, takes entry writes, and
// steps a query through up to four levels with one shared address unit.
// ----------------------------------------------------------------------------
module ptw_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type_i,
  input  logic [ptw_pkg::WIDX_W-1:0] word_index_i,
  input  ptw_pkg::entry_t          entry_value_i,
  input  logic [ptw_pkg::VA_W-1:0] virt_addr_i,
  input  ptw_pkg::root_t           root_i,
  output ptw_pkg::mem_req_t        mem_req_o,
  input  ptw_pkg::entry_t          rdata_i,
  output logic                     result_strobe_o,
  output logic                     mapped_o
);
  import ptw_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;

  // level of the entry held in the read data register
  localparam logic [1:0] LVL_4 = 2'd3;
  localparam logic [1:0] LVL_3 = 2'd2;
  localparam logic [1:0] LVL_2 = 2'd1;
  localparam logic [1:0] LVL_1 = 2'd0;

  localparam addr_t CLR_LAST = addr_t'(TABLE_WORDS - 1);

  logic [1:0]      state_q, state_d;
  logic [1:0]      lvl_q, lvl_d;
  addr_t           clr_q, clr_d;
  logic [VA_W-1:0] va_q, va_d;
  logic            strobe_q, strobe_d;
  logic            mapped_q, mapped_d;

  logic  accept;
  logic  present;
  logic  pagesize;
  root_t base_sel;
  idx_t  idx_sel;
  idx_t  next_idx;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign present  = rdata_i[BIT_PRESENT];
  assign pagesize = rdata_i[BIT_PAGESIZE];

  always_comb begin
    unique case (lvl_q)
      LVL_4:   next_idx = va_q[L3_SHIFT +: IDX_W];
      LVL_3:   next_idx = va_q[L2_SHIFT +: IDX_W];
      default: next_idx = va_q[L1_SHIFT +: IDX_W];
    endcase
  end

  // shared address unit: root on the first level, entry base afterwards
  always_comb begin
    if (state_q == ST_WALK) begin
      base_sel = rdata_i[ROOT_W-1:0];
      idx_sel  = next_idx;
    end else begin
      base_sel = root_i;
      idx_sel  = virt_addr_i[L4_SHIFT +: IDX_W];
    end
  end

  always_comb begin
    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = clr_q;
    mem_req_o.wdata = '0;
    mem_req_o.raddr = entry_addr(base_sel, idx_sel);
    state_d  = state_q;
    lvl_d    = lvl_q;
    clr_d    = clr_q;
    va_d     = va_q;
    strobe_d = 1'b0;
    mapped_d = mapped_q;

    unique case (state_q)
      ST_CLEAR: begin
        mem_req_o.we = 1'b1;
        clr_d        = clr_q + addr_t'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_req_o.waddr = addr_t'(word_index_i);
        mem_req_o.wdata = entry_value_i;
        if (accept) begin
          if (req_type_i == REQ_WRITE) begin
            mem_req_o.we = 1'b1;
          end else begin
            va_d    = virt_addr_i;
            lvl_d   = LVL_4;
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        priority if (!present) begin
          strobe_d = 1'b1;
          mapped_d = 1'b0;
          state_d  = ST_IDLE;
        end else if (lvl_q == LVL_1 || (pagesize && lvl_q != LVL_4)) begin
          strobe_d = 1'b1;
          mapped_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          lvl_d = lvl_q - 2'd1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      lvl_q    <= LVL_4;
      clr_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      lvl_q    <= lvl_d;
      clr_q    <= clr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    va_q     <= va_d;
    mapped_q <= mapped_d;
  end

  assign result_strobe_o = strobe_q;
  assign mapped_o        = mapped_q;

endmodule

/* hw/rtl/ptw_checker.sv */
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks for the page table walk block, bound to the top level.
// ----------------------------------------------------------------------------
module ptw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic req_type_i,
  input logic result_strobe_o
);
  import ptw_pkg::*;

  // a result only follows a walk cycle and never overlaps one
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> !busy)
    else $error("result strobe while busy");

  a_strobe_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy))
    else $error("result strobe without a preceding walk");

  // an entry write transfer never produces a result
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_WRITE) |=> !result_strobe_o)
    else $error("result after an entry write");

  // a query transfer always starts a walk
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_QUERY) |=> (busy && !result_strobe_o))
    else $error("query did not start a walk");

endmodule

bind page_table_walk_presence ptw_checker u_ptw_checker (.*);

/* tb/page_table_walk_presence_tb.sv */
// ----------------------------------------------------------------------------
// page_table_walk_presence_tb
// Self-checking bench for the four-level page table walk presence block.
// Entry writes build page tables in the block's store, and queries walk them.
// A local copy of the store and the root register predicts every mapped
// answer, which is compared with each strobed result in order. Directed
// walks cover each leaf level and the page-size rules. Random phases then
// mix well-formed table paths with stray writes and queries, under
// different root settings and sender gaps.
// ----------------------------------------------------------------------------
module page_table_walk_presence_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptw_pkg::*;

  localparam int unsigned TBL_W      = ADDR_W - IDX_W;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned PHASE_ITEMS = 345;
  localparam int unsigned SETTLE_CYC = 16;
  localparam int unsigned LVL_SHIFT [4] = '{L4_SHIFT, L3_SHIFT, L2_SHIFT, L1_SHIFT};
  localparam logic [VA_W-1:0]   VA_ONES   = '1;
  localparam logic [ROOT_W-1:0] ROOT_ONES = '1;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                req_type_i;
  logic [WIDX_W-1:0]   word_index_i;
  logic [ENTRY_W-1:0]  entry_value_i;
  logic [VA_W-1:0]     virt_addr_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [ROOT_W-1:0]   cfg_data_i;
  logic                result_strobe_o;
  logic                mapped_o;

  page_table_walk_presence i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .word_index_i    (word_index_i),
    .entry_value_i   (entry_value_i),
    .virt_addr_i     (virt_addr_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .result_strobe_o (result_strobe_o),
    .mapped_o        (mapped_o)
  );

  entry_t      table_copy [TABLE_WORDS];
  root_t       root_reg;
  logic        walk_answer_q [$];
  int unsigned sender_idle_pct;
  int unsigned err_cnt;
  int unsigned query_cnt;
  int unsigned hit_cnt;
  int unsigned write_cnt;
  int unsigned root_cnt;
  int unsigned cycle_cnt;

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("[page_table_walk_presence] ERROR");
      $finish;
    end
  end

  // word of entry idx in the table whose byte base sits in base[51:12]
  function automatic addr_t table_word(root_t base, idx_t idx);
    logic [63:0] w;
    w = (64'(base[ROOT_W-1:BASE_LSB]) << IDX_W) + 64'(idx);
    return addr_t'(w % TABLE_WORDS);
  endfunction

  function automatic logic predict_mapped(logic [VA_W-1:0] va);
    root_t  base;
    entry_t e;
    base = root_reg;
    for (int lvl = 0; lvl < 4; lvl++) begin
      e = table_copy[table_word(base, idx_t'(va >> LVL_SHIFT[lvl]))];
      if (!e[BIT_PRESENT]) return 1'b0;
      // page-size bit only counts at the middle two levels
      if ((lvl == 1 || lvl == 2) && e[BIT_PAGESIZE]) return 1'b1;
      base = e[ROOT_W-1:0];
    end
    return 1'b1;
  endfunction

  // entry pointing at table next_tbl, with random reserved and high bits
  function automatic entry_t make_pte(logic [TBL_W-1:0] next_tbl, logic present,
                                      logic huge_page);
    entry_t v;
    v = {$urandom, $urandom};
    v[BASE_LSB +: TBL_W] = next_tbl;
    v[BIT_PAGESIZE]      = huge_page;
    v[BIT_PRESENT]       = present;
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) begin
      if (walk_answer_q.size() == 0) begin
        $error("result with no query outstanding: mapped %0b", mapped_o);
        err_cnt++;
      end else begin
        logic want;
        want = walk_answer_q.pop_front();
        if (mapped_o !== want) begin
          $error("mapped: expected %0b, actual %0b", want, mapped_o);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_item(logic rtype, logic [WIDX_W-1:0] widx, entry_t val,
                           logic [VA_W-1:0] va);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    req_type_i    <= rtype;
    word_index_i  <= widx;
    entry_value_i <= val;
    virt_addr_i   <= va;
    do @(posedge clk_i); while (busy);
    if (rtype == REQ_WRITE) begin
      table_copy[addr_t'(widx % TABLE_WORDS)] = val;
      write_cnt++;
    end else begin
      logic ans;
      ans = predict_mapped(va);
      walk_answer_q.push_back(ans);
      query_cnt++;
      if (ans) hit_cnt++;
    end
  endtask

  task automatic put_entry(logic [TBL_W-1:0] tbl, idx_t idx, entry_t val);
    send_item(REQ_WRITE, WIDX_W'({tbl, idx}), val, VA_W'({$urandom, $urandom}));
  endtask

  task automatic ask(logic [VA_W-1:0] va);
    send_item(REQ_QUERY, WIDX_W'($urandom), {$urandom, $urandom}, va);
  endtask

  // drop start, let every answer come back, then allow for a write in flight
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (walk_answer_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_root(root_t value);
    @(negedge clk_i);
    start       <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    root_reg = value;
    root_cnt++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic walk_sequence();
    logic [VA_W-1:0]  va;
    logic [TBL_W-1:0] nxt [3];
    logic [TBL_W-1:0] cur;
    va = VA_W'({$urandom, $urandom});
    foreach (nxt[i]) nxt[i] = TBL_W'($urandom);
    cur = root_reg[BASE_LSB +: TBL_W];
    put_entry(cur, idx_t'(va >> L4_SHIFT),
              make_pte(nxt[0], $urandom_range(0, 15) != 0, 1'($urandom)));
    put_entry(nxt[0], idx_t'(va >> L3_SHIFT),
              make_pte(nxt[1], $urandom_range(0, 11) != 0, $urandom_range(0, 3) == 0));
    put_entry(nxt[1], idx_t'(va >> L2_SHIFT),
              make_pte(nxt[2], $urandom_range(0, 11) != 0, $urandom_range(0, 3) == 0));
    // sometimes leave the lowest entry as whatever the store already holds
    if ($urandom_range(0, 3) != 0) begin
      put_entry(nxt[2], idx_t'(va >> L1_SHIFT),
                make_pte(TBL_W'($urandom), $urandom_range(0, 7) != 0, 1'($urandom)));
    end
    ask(va);
    if ($urandom_range(0, 2) == 0) ask(va ^ (VA_W'(1) << $urandom_range(0, VA_W - 1)));
  endtask

  // store is cleared by reset; root low bits are ignored
  task automatic test_after_reset();
    write_root(root_t'(12'hFFF));
    ask('0);
    ask(VA_ONES);
    settle();
  endtask

  // all-ones address, tables 0 -> 1 -> 2 -> 3 -> 4
  task automatic test_leaf_levels();
    put_entry(TBL_W'(0), '1, make_pte(TBL_W'(1), 1'b1, 1'b0));
    put_entry(TBL_W'(1), '1, make_pte(TBL_W'(2), 1'b1, 1'b0));
    put_entry(TBL_W'(2), '1, make_pte(TBL_W'(3), 1'b1, 1'b0));
    put_entry(TBL_W'(3), '1, make_pte(TBL_W'(4), 1'b1, 1'b0));
    ask(VA_ONES);
    put_entry(TBL_W'(1), '1, make_pte(TBL_W'(2), 1'b1, 1'b1));
    ask(VA_ONES);
    put_entry(TBL_W'(1), '1, make_pte(TBL_W'(2), 1'b1, 1'b0));
    put_entry(TBL_W'(2), '1, make_pte(TBL_W'(3), 1'b1, 1'b1));
    ask(VA_ONES);
    put_entry(TBL_W'(2), '1, make_pte(TBL_W'(3), 1'b0, 1'b1));
    ask(VA_ONES);
    settle();
  endtask

  task automatic test_page_size_rules();
    // page-size at the top level must not end the walk
    put_entry(TBL_W'(0), '1, make_pte(TBL_W'(1), 1'b1, 1'b1));
    put_entry(TBL_W'(2), '1, make_pte(TBL_W'(3), 1'b1, 1'b0));
    put_entry(TBL_W'(3), '1, make_pte(TBL_W'(4), 1'b1, 1'b1));
    ask(VA_ONES);
    put_entry(TBL_W'(3), '1, make_pte(TBL_W'(4), 1'b0, 1'b1));
    ask(VA_ONES);
    put_entry(TBL_W'(0), '1, make_pte(TBL_W'(1), 1'b1, 1'b1));
    put_entry(TBL_W'(1), '1, make_pte(TBL_W'(2), 1'b0, 1'b1));
    ask(VA_ONES);
    settle();
  endtask

  task automatic test_root_register();
    root_t r;
    write_root(ROOT_ONES);
    ask(VA_ONES);
    settle();
    r = {$urandom, $urandom};
    r[BASE_LSB +: TBL_W] = '0;
    write_root(r);
    put_entry(TBL_W'(1), '1, make_pte(TBL_W'(2), 1'b1, 1'b0));
    put_entry(TBL_W'(3), '1, make_pte(TBL_W'(4), 1'b1, 1'b0));
    ask(VA_ONES);
    settle();
  endtask

  task automatic random_phase(int unsigned idle_pct, root_t root_val);
    int unsigned start_items;
    int unsigned r;
    write_root(root_val);
    sender_idle_pct = idle_pct;
    start_items = query_cnt + write_cnt;
    while (query_cnt + write_cnt - start_items < PHASE_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        walk_sequence();
      end else if (r < 88) begin
        send_item(REQ_WRITE, WIDX_W'($urandom), {$urandom, $urandom},
                  VA_W'({$urandom, $urandom}));
      end else begin
        ask(VA_W'({$urandom, $urandom}));
      end
    end
    settle();
  endtask

  task automatic test_random_walks();
    random_phase(32, root_t'({$urandom, $urandom}));
    random_phase(61, ROOT_ONES);
    random_phase(0, '0);
  endtask

  initial begin
    start           = 1'b0;
    req_type_i      = REQ_WRITE;
    word_index_i    = '0;
    entry_value_i   = '0;
    virt_addr_i     = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    root_reg        = '0;
    sender_idle_pct = 0;
    err_cnt         = 0;
    query_cnt       = 0;
    hit_cnt         = 0;
    write_cnt       = 0;
    root_cnt        = 0;
    cycle_cnt       = 0;
    foreach (table_copy[i]) table_copy[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_leaf_levels();
    test_page_size_rules();
    test_root_register();
    test_random_walks();

    $display("covered %0d queries (%0d mapped) and %0d entry writes", query_cnt, hit_cnt,
             write_cnt);
    $display("over %0d root settings, sender gaps of 0, 32 and 61 percent", root_cnt);
    if (err_cnt == 0) begin
      $display("[page_table_walk_presence] OK");
    end else begin
      $display("[page_table_walk_presence] ERROR");
    end
    $finish;
  end

endmodule
